// ----- design/wia_pkg.sv -----
// ----------------------------------------------------------------------------
// wia_pkg
// Shared types and constants of the wide integer accumulator ALU: operation
// and compare codes, word geometry and the word unit's control and result.
// ----------------------------------------------------------------------------
package wia_pkg;

   localparam int WORD_W     = 64;
   localparam int WIDTH_DEF  = 256;
   localparam int OP_W       = 4;
   localparam int INDEX_W    = 2;
   localparam int CMP_RES_W  = 2;

   localparam logic [WORD_W-1:0] WORD_ONE = {{(WORD_W-1){1'b0}}, 1'b1};

   localparam logic [OP_W-1:0] OP_LOAD = 4'd0;
   localparam logic [OP_W-1:0] OP_ADD  = 4'd1;
   localparam logic [OP_W-1:0] OP_AND  = 4'd2;
   localparam logic [OP_W-1:0] OP_OR   = 4'd3;
   localparam logic [OP_W-1:0] OP_XOR  = 4'd4;
   localparam logic [OP_W-1:0] OP_CMP  = 4'd5;
   localparam logic [OP_W-1:0] OP_INC  = 4'd6;
   localparam logic [OP_W-1:0] OP_DEC  = 4'd7;
   localparam logic [OP_W-1:0] OP_READ = 4'd8;

   localparam logic [CMP_RES_W-1:0] CMP_EQ = 2'd0;
   localparam logic [CMP_RES_W-1:0] CMP_GT = 2'd1;
   localparam logic [CMP_RES_W-1:0] CMP_LT = 2'd2;

   typedef struct packed {
      logic            first;
      logic            last;
      logic [OP_W-1:0] op;
   } word_ctl_type;

   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic              carry;
      logic              over;
      logic              gt;
      logic              lt;
   } word_res_type;

endpackage

// ----- design/wia_word_alu.sv -----
// ----------------------------------------------------------------------------
// wia_word_alu
// One 64-bit digit of the accumulator datapath: add/increment carry chain,
// decrement borrow chain, load, low-word logic ops, word compare, top-word
// masking and overflow detection.
// ----------------------------------------------------------------------------
module wia_word_alu #(
   parameter int WIDTH = wia_pkg::WIDTH_DEF
) (
   input  wia_pkg::word_ctl_type            ctl,
   input  logic [wia_pkg::WORD_W-1:0]       word,
   input  logic [wia_pkg::WORD_W-1:0]       operand,
   input  logic                             carry_in,
   output wia_pkg::word_res_type            res
);

   localparam int WW       = wia_pkg::WORD_W;
   localparam int NWORDS   = (WIDTH + WW - 1) / WW;
   localparam int TOP_BITS = WIDTH - WW * (NWORDS - 1);
   localparam logic [WW-1:0] TOP_MASK = {WW{1'b1}} >> (WW - TOP_BITS);

   logic [WW-1:0] addend;
   logic [WW-1:0] subtrahend;
   logic          cin;
   logic [WW:0]   sum;
   logic [WW:0]   diff;
   logic [WW-1:0] new_word;
   logic          carry_out;

   always_comb begin
      addend     = '0;
      cin        = ctl.first ? 1'b0 : carry_in;
      subtrahend = ctl.first ? wia_pkg::WORD_ONE : {{(WW-1){1'b0}}, carry_in};
      if (ctl.first) begin
         if (ctl.op == wia_pkg::OP_ADD) begin
            addend = operand;
         end else if (ctl.op == wia_pkg::OP_INC) begin
            addend = wia_pkg::WORD_ONE;
         end
      end
      sum  = {1'b0, word} + {1'b0, addend} + {{WW{1'b0}}, cin};
      diff = {1'b0, word} - {1'b0, subtrahend};
   end

   always_comb begin
      new_word  = word;
      carry_out = 1'b0;
      case (ctl.op)
         wia_pkg::OP_LOAD: begin
            new_word = ctl.first ? operand : '0;
         end
         wia_pkg::OP_ADD, wia_pkg::OP_INC: begin
            new_word  = sum[WW-1:0];
            carry_out = sum[WW];
         end
         wia_pkg::OP_DEC: begin
            new_word  = diff[WW-1:0];
            carry_out = diff[WW];
         end
         wia_pkg::OP_AND: begin
            new_word = ctl.first ? (word & operand) : word;
         end
         wia_pkg::OP_OR: begin
            new_word = ctl.first ? (word | operand) : word;
         end
         wia_pkg::OP_XOR: begin
            new_word = ctl.first ? (word ^ operand) : word;
         end
         default: begin
            new_word = word;
         end
      endcase
   end

   always_comb begin
      res.word  = ctl.last ? (new_word & TOP_MASK) : new_word;
      res.carry = carry_out;
      res.over  = ctl.last && (carry_out || ((new_word & ~TOP_MASK) != '0));
      res.gt    = word > operand;
      res.lt    = word < operand;
   end

endmodule

// ----- design/wide_integer_accumulator_alu.sv -----
// ----------------------------------------------------------------------------
// wide_integer_accumulator_alu
// WIDTH-bit unsigned accumulator with load, add, low-word logic, compare,
// increment, decrement and word read, one 64-bit word per cycle unless frozen.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_type, req_operand,
//                                            req_word_index
//   rsp      out        rsp_valid/rsp_stall  rsp_read_word, rsp_compare_result,
//                                            rsp_wrap_flag, rsp_zero_flag
//
// In a transaction the accumulator words rotate once through the single
// 64-bit word ALU, least significant first. The next transaction is
// accepted in the cycle the previous one ends. Reset clears the accumulator,
// the busy flag, the word counter and the response valid flag.
// A result waits in the output register; the word ALU only freezes on its
// final word while an earlier result is still stalled.
// ----------------------------------------------------------------------------
module wide_integer_accumulator_alu #(
   parameter int WIDTH = wia_pkg::WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [wia_pkg::OP_W-1:0]            req_type,
   input  logic [wia_pkg::WORD_W-1:0]          req_operand,
   input  logic [wia_pkg::INDEX_W-1:0]         req_word_index,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [wia_pkg::WORD_W-1:0]          rsp_read_word,
   output logic [wia_pkg::CMP_RES_W-1:0]       rsp_compare_result,
   output logic                                rsp_wrap_flag,
   output logic                                rsp_zero_flag
);

   localparam int WW     = wia_pkg::WORD_W;
   localparam int NWORDS = (WIDTH + WW - 1) / WW;
   localparam int CNT_W  = (NWORDS > 1) ? $clog2(NWORDS) : 1;
   localparam int IW     = wia_pkg::INDEX_W;
   localparam int MW     = (CNT_W > IW) ? CNT_W : IW;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NWORDS - 1);

   logic [WW-1:0]                 acc_ff [NWORDS];
   logic [WW-1:0]                 acc_in [NWORDS];
   logic                          busy_ff, busy_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [wia_pkg::OP_W-1:0]      op_ff, op_in;
   logic [WW-1:0]                 operand_ff, operand_in;
   logic [IW-1:0]                 idx_ff, idx_in;
   logic                          carry_ff, carry_in;
   logic                          old_nz_ff, old_nz_in;
   logic                          new_nz_ff, new_nz_in;
   logic                          upper_ff, upper_in;
   logic                          gt_ff, gt_in;
   logic                          lt_ff, lt_in;
   logic [WW-1:0]                 rd_ff, rd_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [WW-1:0]                 rsp_read_word_ff, rsp_read_word_in;
   logic [wia_pkg::CMP_RES_W-1:0] rsp_cmp_ff, rsp_cmp_in;
   logic                          rsp_wrap_ff, rsp_wrap_in;
   logic                          rsp_zero_ff, rsp_zero_in;

   logic                          last;
   logic                          hold;
   logic                          step;
   logic                          done;
   logic                          accept;
   logic                          rsp_pop;
   logic                          nx_old_nz;
   logic                          nx_new_nz;
   logic                          nx_upper;
   logic                          nx_gt;
   logic                          nx_lt;
   logic [WW-1:0]                 nx_rd;
   wia_pkg::word_ctl_type         ctl;
   wia_pkg::word_res_type         res;

   assign last    = cnt_ff == CNT_LAST;
   assign hold    = last && rsp_valid_ff && rsp_stall;
   assign step    = busy_ff && !hold;
   assign done    = step && last;
   assign rsp_pop = rsp_valid_ff && !rsp_stall;

   assign req_stall = busy_ff && !done;
   assign accept    = req_valid && !req_stall;

   assign ctl.first = cnt_ff == '0;
   assign ctl.last  = last;
   assign ctl.op    = op_ff;

   wia_word_alu #(
      .WIDTH (WIDTH)
   ) u_word_alu (
      .ctl      (ctl),
      .word     (acc_ff[0]),
      .operand  (operand_ff),
      .carry_in (carry_ff),
      .res      (res)
   );

   always_comb begin
      nx_old_nz = old_nz_ff || (acc_ff[0] != '0);
      nx_new_nz = new_nz_ff || (res.word != '0);
      nx_upper  = upper_ff || (!ctl.first && (acc_ff[0] != '0));
      nx_gt     = ctl.first ? res.gt : gt_ff;
      nx_lt     = ctl.first ? res.lt : lt_ff;
      nx_rd     = rd_ff;
      if ((op_ff == wia_pkg::OP_READ) && (MW'(cnt_ff) == MW'(idx_ff))) begin
         nx_rd = acc_ff[0];
      end
   end

   always_comb begin
      for (int i = 0; i < NWORDS; i++) begin
         acc_in[i] = acc_ff[i];
      end
      if (step) begin
         for (int i = 0; i < NWORDS - 1; i++) begin
            acc_in[i] = acc_ff[i + 1];
         end
         acc_in[NWORDS - 1] = res.word;
      end

      busy_in    = busy_ff;
      cnt_in     = cnt_ff;
      op_in      = op_ff;
      operand_in = operand_ff;
      idx_in     = idx_ff;
      carry_in   = carry_ff;
      old_nz_in  = old_nz_ff;
      new_nz_in  = new_nz_ff;
      upper_in   = upper_ff;
      gt_in      = gt_ff;
      lt_in      = lt_ff;
      rd_in      = rd_ff;
      if (step) begin
         cnt_in    = last ? '0 : cnt_ff + CNT_W'(1);
         busy_in   = !last;
         carry_in  = res.carry;
         old_nz_in = nx_old_nz;
         new_nz_in = nx_new_nz;
         upper_in  = nx_upper;
         gt_in     = nx_gt;
         lt_in     = nx_lt;
         rd_in     = nx_rd;
      end
      if (accept) begin
         busy_in    = 1'b1;
         cnt_in     = '0;
         op_in      = req_type;
         operand_in = req_operand;
         idx_in     = req_word_index;
         carry_in   = 1'b0;
         old_nz_in  = 1'b0;
         new_nz_in  = 1'b0;
         upper_in   = 1'b0;
         gt_in      = 1'b0;
         lt_in      = 1'b0;
         rd_in      = '0;
      end
   end

   always_comb begin
      rsp_valid_in     = rsp_valid_ff;
      rsp_read_word_in = rsp_read_word_ff;
      rsp_cmp_in       = rsp_cmp_ff;
      rsp_wrap_in      = rsp_wrap_ff;
      rsp_zero_in      = rsp_zero_ff;
      if (rsp_pop) begin
         rsp_valid_in = 1'b0;
      end
      if (done) begin
         rsp_valid_in     = 1'b1;
         rsp_read_word_in = nx_rd;
         rsp_zero_in      = !nx_new_nz;
         rsp_cmp_in       = wia_pkg::CMP_EQ;
         if (op_ff == wia_pkg::OP_CMP) begin
            if (nx_upper || nx_gt) begin
               rsp_cmp_in = wia_pkg::CMP_GT;
            end else if (nx_lt) begin
               rsp_cmp_in = wia_pkg::CMP_LT;
            end
         end
         case (op_ff)
            wia_pkg::OP_ADD: rsp_wrap_in = res.over;
            wia_pkg::OP_INC: rsp_wrap_in = !nx_new_nz;
            wia_pkg::OP_DEC: rsp_wrap_in = !nx_old_nz;
            default:         rsp_wrap_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NWORDS; i++) begin
            acc_ff[i] <= '0;
         end
         busy_ff      <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         for (int i = 0; i < NWORDS; i++) begin
            acc_ff[i] <= acc_in[i];
         end
         busy_ff      <= busy_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff            <= op_in;
      operand_ff       <= operand_in;
      idx_ff           <= idx_in;
      carry_ff         <= carry_in;
      old_nz_ff        <= old_nz_in;
      new_nz_ff        <= new_nz_in;
      upper_ff         <= upper_in;
      gt_ff            <= gt_in;
      lt_ff            <= lt_in;
      rd_ff            <= rd_in;
      rsp_read_word_ff <= rsp_read_word_in;
      rsp_cmp_ff       <= rsp_cmp_in;
      rsp_wrap_ff      <= rsp_wrap_in;
      rsp_zero_ff      <= rsp_zero_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_word      = rsp_read_word_ff;
   assign rsp_compare_result = rsp_cmp_ff;
   assign rsp_wrap_flag      = rsp_wrap_ff;
   assign rsp_zero_flag      = rsp_zero_ff;

   // word walk restarts at the least significant word
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> busy_ff && (cnt_ff == '0))
      else $error("accepted transaction did not start a word walk");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff <= CNT_LAST)
      else $error("word counter past top word");

   a_read_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_read_word != '0) |-> !rsp_zero_flag)
      else $error("nonzero word read while zero flag set");

   a_cmp_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_compare_result != wia_pkg::CMP_EQ)
         |-> !rsp_wrap_flag && (rsp_read_word == '0))
      else $error("compare result alongside other result fields");

   a_cmp_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_compare_result == wia_pkg::CMP_EQ)
         || (rsp_compare_result == wia_pkg::CMP_GT)
         || (rsp_compare_result == wia_pkg::CMP_LT))
      else $error("reserved compare code");

endmodule
